[hdl/eatra_pkg.sv]
// Shared constants, types and rounding helpers for the Euler angle to view axes unit.
`default_nettype none

package eatra_pkg;

	// Field formats
	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = 14;
	localparam int OUT_W        = FRAC_BITS + 2;
	localparam int IN_FIELDS_W  = 3 * ANGLE_BITS;
	localparam int OUT_FIELDS_W = 9 * OUT_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// CORDIC rotator: Q2.30 values, 32-bit binary angle, two guard bits
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;
	localparam int PIPE_STAGES  = 38;

	typedef logic [ANGLE_BITS-1:0]  angle_t;
	typedef logic signed [CW-1:0]   cval_t;
	typedef logic signed [31:0]     q30_t;
	typedef logic signed [63:0]     prod_t;
	typedef logic signed [32:0]     sum_t;
	typedef logic signed [OUT_W-1:0] out_t;

	localparam cval_t X_INIT    = 34'sh026DD3B6A;
	localparam cval_t Q30_ONE   = 34'sd1 <<< 30;
	localparam cval_t HALF_TURN = 34'sd1 <<< 31;

	localparam cval_t ATAN_TURN32 [CORDIC_STEPS] = '{
		34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4, 34'sh0028B0D43,
		34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55, 34'sh00028BE53, 34'sh000145F2F,
		34'sh0000A2F98, 34'sh0000517CC, 34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA,
		34'sh00000517D, 34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
		34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051, 34'sh000000029,
		34'sh000000014, 34'sh00000000A, 34'sh000000005, 34'sh000000003, 34'sh000000001
	};

	localparam prod_t PROD_HALF = 64'sd1 <<< 29;

	localparam int RND_SH = 30 - FRAC_BITS;
	localparam logic signed [33:0] RND_HALF = (34'sd1 <<< RND_SH) >>> 1;
	localparam logic signed [33:0] OUT_ONE  = 34'sd1 <<< FRAC_BITS;

	// Round a Q60 product back to Q30, half up.
	function automatic q30_t mul_round(prod_t p);
		prod_t t;
		t = p + PROD_HALF;
		return t[61:30];
	endfunction

	// Round a Q30 sum to the output format, half up, and saturate to unity.
	function automatic out_t to_out(sum_t v);
		logic signed [33:0] t;
		logic signed [33:0] r;
		t = 34'(v) + RND_HALF;
		r = t >>> RND_SH;
		if (r > OUT_ONE) begin
			r = OUT_ONE;
		end else if (r < -OUT_ONE) begin
			r = -OUT_ONE;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/eatra_cordic.sv]
// Pipelined CORDIC rotator: one angle in, its sine and cosine in Q30 out.
`default_nettype none

module eatra_cordic (
	input  wire                    clk,
	input  wire                    en,
	input  wire eatra_pkg::angle_t angle,
	output eatra_pkg::q30_t        sin_val,
	output eatra_pkg::q30_t        cos_val
);

	localparam int N = eatra_pkg::CORDIC_STEPS;

	logic [31:0]      a32;
	eatra_pkg::cval_t z_raw;
	eatra_pkg::cval_t z_fold;
	logic             flip_fold;

	// x_s[k], y_s[k], z_s[k] sit in stage k+1: fold first, then one per rotation
	eatra_pkg::cval_t x_s [N+1];
	eatra_pkg::cval_t y_s [N+1];
	eatra_pkg::cval_t z_s [N+1];
	logic             flip_s [N+1];

	eatra_pkg::cval_t xf;
	eatra_pkg::cval_t yf;
	eatra_pkg::q30_t  sin_s32;
	eatra_pkg::q30_t  cos_s32;

	// Fold the angle into the half turn around zero; negate at the end.
	always_comb begin
		a32   = 32'(angle) << (32 - eatra_pkg::ANGLE_BITS);
		z_raw = eatra_pkg::cval_t'(signed'(a32));
		if (z_raw > eatra_pkg::Q30_ONE) begin
			z_fold    = z_raw - eatra_pkg::HALF_TURN;
			flip_fold = 1'b1;
		end else if (z_raw < -eatra_pkg::Q30_ONE) begin
			z_fold    = z_raw + eatra_pkg::HALF_TURN;
			flip_fold = 1'b1;
		end else begin
			z_fold    = z_raw;
			flip_fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= eatra_pkg::X_INIT;
			y_s[0]    <= '0;
			z_s[0]    <= z_fold;
			flip_s[0] <= flip_fold;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][eatra_pkg::CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - eatra_pkg::ATAN_TURN32[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + eatra_pkg::ATAN_TURN32[i];
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	// Undo the fold and clamp to unity.
	always_comb begin
		xf = flip_s[N] ? -x_s[N] : x_s[N];
		yf = flip_s[N] ? -y_s[N] : y_s[N];
		if (xf > eatra_pkg::Q30_ONE) begin
			xf = eatra_pkg::Q30_ONE;
		end else if (xf < -eatra_pkg::Q30_ONE) begin
			xf = -eatra_pkg::Q30_ONE;
		end
		if (yf > eatra_pkg::Q30_ONE) begin
			yf = eatra_pkg::Q30_ONE;
		end else if (yf < -eatra_pkg::Q30_ONE) begin
			yf = -eatra_pkg::Q30_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s32 <= xf[31:0];
			sin_s32 <= yf[31:0];
		end
	end

	assign sin_val = sin_s32;
	assign cos_val = cos_s32;

endmodule

`default_nettype wire

[hdl/euler_angles_to_rotation_axes_unit.sv]
// Top level: pitch, yaw, roll beats in; forward, left and up view axes out.
// Throughput: one beat per cycle; s_tready drops only while the skid entry holds a beat.
// Stages: angle fold, 30 CORDIC rotations, clamp, two multiply/round pairs, sum, output rounding.
// A two-entry output buffer (output register plus skid) keeps s_tready high while one result waits.
// Reset: arst_n clears valid bits only; no state survives between beats.
`default_nettype none

module euler_angles_to_rotation_axes_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// s_tdata fields, low bit up: pitch, yaw, roll
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire [eatra_pkg::IN_TDATA_W-1:0]      s_tdata,
	// m_tdata fields, low bit up: forward_x, forward_y, forward_z,
	// left_x, left_y, left_z, up_x, up_y, up_z
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [eatra_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int AB = eatra_pkg::ANGLE_BITS;
	localparam int NS = eatra_pkg::PIPE_STAGES;

	logic en;

	eatra_pkg::angle_t pitch;
	eatra_pkg::angle_t yaw;
	eatra_pkg::angle_t roll;

	eatra_pkg::q30_t sp, cp, sy, cy, sr, cr;

	// Stage 33: raw first-level products
	eatra_pkg::prod_t p_cpcy_s33, p_cpsy_s33, p_crsy_s33, p_crcy_s33, p_srcp_s33;
	eatra_pkg::prod_t p_srsy_s33, p_srcy_s33, p_crcp_s33, p_srsp_s33, p_crsp_s33;
	eatra_pkg::q30_t  sp_s33, sy_s33, cy_s33;

	// Stage 34: rounded first-level products
	eatra_pkg::q30_t cpcy_s34, cpsy_s34, crsy_s34, crcy_s34, srcp_s34;
	eatra_pkg::q30_t srsy_s34, srcy_s34, crcp_s34, srsp_s34, crsp_s34;
	eatra_pkg::q30_t sp_s34, sy_s34, cy_s34;

	// Stage 35: raw triple products
	eatra_pkg::prod_t p_srspcy_s35, p_srspsy_s35, p_crspcy_s35, p_crspsy_s35;
	eatra_pkg::q30_t  cpcy_s35, cpsy_s35, crsy_s35, crcy_s35, srcp_s35;
	eatra_pkg::q30_t  srsy_s35, srcy_s35, crcp_s35, sp_s35;

	// Stage 36: rounded triple products
	eatra_pkg::q30_t srspcy_s36, srspsy_s36, crspcy_s36, crspsy_s36;
	eatra_pkg::q30_t cpcy_s36, cpsy_s36, crsy_s36, crcy_s36, srcp_s36;
	eatra_pkg::q30_t srsy_s36, srcy_s36, crcp_s36, sp_s36;

	// Stage 37: Q30 axis entries
	eatra_pkg::sum_t fx_s37, fy_s37, fz_s37, lx_s37, ly_s37, lz_s37, ux_s37, uy_s37, uz_s37;

	// Stage 38: packed result
	logic [eatra_pkg::OUT_FIELDS_W-1:0] res_s38;

	// Output buffer
	logic [NS-1:0]                      vld_q;
	logic                               out_vld_q;
	logic                               skid_vld_q;
	logic [eatra_pkg::OUT_FIELDS_W-1:0] res_q;
	logic [eatra_pkg::OUT_FIELDS_W-1:0] skid_data_q;

	// The whole pipeline moves together unless the skid entry is occupied.
	assign en       = !skid_vld_q;
	assign s_tready = en;

	assign pitch = s_tdata[AB-1:0];
	assign yaw   = s_tdata[2*AB-1:AB];
	assign roll  = s_tdata[3*AB-1:2*AB];

	// Stages 1 to 32: one rotator per angle
	eatra_cordic u_cordic_pitch (.clk(clk), .en(en), .angle(pitch), .sin_val(sp), .cos_val(cp));
	eatra_cordic u_cordic_yaw   (.clk(clk), .en(en), .angle(yaw),   .sin_val(sy), .cos_val(cy));
	eatra_cordic u_cordic_roll  (.clk(clk), .en(en), .angle(roll),  .sin_val(sr), .cos_val(cr));

	// Stage 33: the pairwise products the axes need, sign-extended to full width
	always_ff @(posedge clk) begin
		if (en) begin
			p_cpcy_s33 <= eatra_pkg::prod_t'(cp) * eatra_pkg::prod_t'(cy);
			p_cpsy_s33 <= eatra_pkg::prod_t'(cp) * eatra_pkg::prod_t'(sy);
			p_crsy_s33 <= eatra_pkg::prod_t'(cr) * eatra_pkg::prod_t'(sy);
			p_crcy_s33 <= eatra_pkg::prod_t'(cr) * eatra_pkg::prod_t'(cy);
			p_srcp_s33 <= eatra_pkg::prod_t'(sr) * eatra_pkg::prod_t'(cp);
			p_srsy_s33 <= eatra_pkg::prod_t'(sr) * eatra_pkg::prod_t'(sy);
			p_srcy_s33 <= eatra_pkg::prod_t'(sr) * eatra_pkg::prod_t'(cy);
			p_crcp_s33 <= eatra_pkg::prod_t'(cr) * eatra_pkg::prod_t'(cp);
			p_srsp_s33 <= eatra_pkg::prod_t'(sr) * eatra_pkg::prod_t'(sp);
			p_crsp_s33 <= eatra_pkg::prod_t'(cr) * eatra_pkg::prod_t'(sp);
			sp_s33     <= sp;
			sy_s33     <= sy;
			cy_s33     <= cy;
		end
	end

	// Stage 34: round back to Q30
	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s34 <= eatra_pkg::mul_round(p_cpcy_s33);
			cpsy_s34 <= eatra_pkg::mul_round(p_cpsy_s33);
			crsy_s34 <= eatra_pkg::mul_round(p_crsy_s33);
			crcy_s34 <= eatra_pkg::mul_round(p_crcy_s33);
			srcp_s34 <= eatra_pkg::mul_round(p_srcp_s33);
			srsy_s34 <= eatra_pkg::mul_round(p_srsy_s33);
			srcy_s34 <= eatra_pkg::mul_round(p_srcy_s33);
			crcp_s34 <= eatra_pkg::mul_round(p_crcp_s33);
			srsp_s34 <= eatra_pkg::mul_round(p_srsp_s33);
			crsp_s34 <= eatra_pkg::mul_round(p_crsp_s33);
			sp_s34   <= sp_s33;
			sy_s34   <= sy_s33;
			cy_s34   <= cy_s33;
		end
	end

	// Stage 35: roll-pitch products times the yaw terms
	always_ff @(posedge clk) begin
		if (en) begin
			p_srspcy_s35 <= eatra_pkg::prod_t'(srsp_s34) * eatra_pkg::prod_t'(cy_s34);
			p_srspsy_s35 <= eatra_pkg::prod_t'(srsp_s34) * eatra_pkg::prod_t'(sy_s34);
			p_crspcy_s35 <= eatra_pkg::prod_t'(crsp_s34) * eatra_pkg::prod_t'(cy_s34);
			p_crspsy_s35 <= eatra_pkg::prod_t'(crsp_s34) * eatra_pkg::prod_t'(sy_s34);
			cpcy_s35     <= cpcy_s34;
			cpsy_s35     <= cpsy_s34;
			crsy_s35     <= crsy_s34;
			crcy_s35     <= crcy_s34;
			srcp_s35     <= srcp_s34;
			srsy_s35     <= srsy_s34;
			srcy_s35     <= srcy_s34;
			crcp_s35     <= crcp_s34;
			sp_s35       <= sp_s34;
		end
	end

	// Stage 36: round the triple products
	always_ff @(posedge clk) begin
		if (en) begin
			srspcy_s36 <= eatra_pkg::mul_round(p_srspcy_s35);
			srspsy_s36 <= eatra_pkg::mul_round(p_srspsy_s35);
			crspcy_s36 <= eatra_pkg::mul_round(p_crspcy_s35);
			crspsy_s36 <= eatra_pkg::mul_round(p_crspsy_s35);
			cpcy_s36   <= cpcy_s35;
			cpsy_s36   <= cpsy_s35;
			crsy_s36   <= crsy_s35;
			crcy_s36   <= crcy_s35;
			srcp_s36   <= srcp_s35;
			srsy_s36   <= srsy_s35;
			srcy_s36   <= srcy_s35;
			crcp_s36   <= crcp_s35;
			sp_s36     <= sp_s35;
		end
	end

	// Stage 37: exact Q30 sums; one guard bit covers entries slightly past unity
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s37 <= eatra_pkg::sum_t'(cpcy_s36);
			fy_s37 <= eatra_pkg::sum_t'(cpsy_s36);
			fz_s37 <= -eatra_pkg::sum_t'(sp_s36);
			lx_s37 <= eatra_pkg::sum_t'(srspcy_s36) - eatra_pkg::sum_t'(crsy_s36);
			ly_s37 <= eatra_pkg::sum_t'(srspsy_s36) + eatra_pkg::sum_t'(crcy_s36);
			lz_s37 <= eatra_pkg::sum_t'(srcp_s36);
			ux_s37 <= eatra_pkg::sum_t'(crspcy_s36) + eatra_pkg::sum_t'(srsy_s36);
			uy_s37 <= eatra_pkg::sum_t'(crspsy_s36) - eatra_pkg::sum_t'(srcy_s36);
			uz_s37 <= eatra_pkg::sum_t'(crcp_s36);
		end
	end

	// Stage 38: round to the output format, saturate, pack with forward_x lowest
	always_ff @(posedge clk) begin
		if (en) begin
			res_s38 <= {eatra_pkg::to_out(uz_s37), eatra_pkg::to_out(uy_s37),
				eatra_pkg::to_out(ux_s37), eatra_pkg::to_out(lz_s37),
				eatra_pkg::to_out(ly_s37), eatra_pkg::to_out(lx_s37),
				eatra_pkg::to_out(fz_s37), eatra_pkg::to_out(fy_s37),
				eatra_pkg::to_out(fx_s37)};
		end
	end

	// Valid bits travel with the data; the output buffer drains the last stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[NS-2:0], s_tvalid};
			end
			if (skid_vld_q) begin
				// pipeline is held; refill the output register from skid once taken
				if (m_tready) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (!out_vld_q || m_tready) begin
				out_vld_q <= vld_q[NS-1];
			end else if (vld_q[NS-1]) begin
				// output still waiting: park the arriving beat
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				res_q <= skid_data_q;
			end
		end else if (!out_vld_q || m_tready) begin
			res_q <= res_s38;
		end else begin
			skid_data_q <= res_s38;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = eatra_pkg::OUT_TDATA_W'(res_q);

endmodule

`default_nettype wire
